// File: rtl/cmt_pkg.sv
// ----------------------------------------------------------------------------
// cmt_pkg: shared types for the chunked microsecond timeout
// Request codes and the per-item result bundle used by the step logic and top.
// ----------------------------------------------------------------------------
package cmt_pkg;

	// Request codes carried on req_type
	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_START = 2'd1,
		REQ_POLL  = 2'd2,
		REQ_STOP  = 2'd3
	} req_t;

	// Result bundle for one beat
	typedef struct packed {
		logic expired;
		logic status;
		logic running;
	} result_t;

	// Width of the microsecond request field
	localparam int unsigned USEC_W = 32;

endpackage

// File: rtl/cmt_chunk.sv
// ----------------------------------------------------------------------------
// cmt_chunk: next chunk of a long timeout
// Caps the outstanding microseconds at the counter limit, converts the chunk
// to reload cycles and returns what is left over.
// ----------------------------------------------------------------------------
module cmt_chunk #(
	parameter int unsigned CYCLES_PER_USEC = 24,
	parameter int unsigned COUNTER_BITS    = 24
) (
	input  logic [cmt_pkg::USEC_W-1:0] amount,
	output logic [cmt_pkg::USEC_W-1:0] remain_next,
	output logic [COUNTER_BITS-1:0]    reload
);
	import cmt_pkg::*;

	localparam int unsigned CPU_W = $clog2(CYCLES_PER_USEC + 1);
	localparam longint unsigned MAX_COUNT_L    = (64'd1 << COUNTER_BITS) - 64'd1;
	localparam longint unsigned CHUNK_MAX_US_L = MAX_COUNT_L / CYCLES_PER_USEC;
	localparam logic [USEC_W-1:0] CHUNK_MAX_US = USEC_W'(CHUNK_MAX_US_L);
	localparam logic [CPU_W-1:0]  CPU_K        = CPU_W'(CYCLES_PER_USEC);

	logic [COUNTER_BITS-1:0]       chunk;
	logic [COUNTER_BITS+CPU_W-1:0] cycles;

	// Cap the chunk at the largest microsecond count whose cycles fit the counter
	always_comb begin
		if (amount < CHUNK_MAX_US) begin
			chunk = amount[COUNTER_BITS-1:0];
		end else begin
			chunk = CHUNK_MAX_US[COUNTER_BITS-1:0];
		end
	end

	assign remain_next = amount - USEC_W'(chunk);

	// Convert microseconds to counter cycles; the product never exceeds the limit
	assign cycles = (COUNTER_BITS+CPU_W)'(chunk) * (COUNTER_BITS+CPU_W)'(CPU_K);
	assign reload = cycles[COUNTER_BITS-1:0];

endmodule

// File: rtl/cmt_step.sv
// ----------------------------------------------------------------------------
// cmt_step: per-request state update
// Applies one tick, start, poll or stop request to the counter state and
// forms the result of that beat.
// ----------------------------------------------------------------------------
module cmt_step #(
	parameter int unsigned CYCLES_PER_USEC = 24,
	parameter int unsigned COUNTER_BITS    = 24
) (
	input  cmt_pkg::req_t                req,
	input  logic [cmt_pkg::USEC_W-1:0]   usecs,
	input  logic [cmt_pkg::USEC_W-1:0]   remain_cur,
	input  logic [COUNTER_BITS-1:0]      reload_cur,
	input  logic [COUNTER_BITS-1:0]      count_cur,
	input  logic                         on_cur,
	input  logic                         wrap_cur,
	output logic [cmt_pkg::USEC_W-1:0]   remain_nxt,
	output logic [COUNTER_BITS-1:0]      reload_nxt,
	output logic [COUNTER_BITS-1:0]      count_nxt,
	output logic                         on_nxt,
	output logic                         wrap_nxt,
	output cmt_pkg::result_t             result
);
	import cmt_pkg::*;

	localparam logic [COUNTER_BITS-1:0] CNT_ONE = COUNTER_BITS'(1);

	logic [USEC_W-1:0]       load_src;
	logic [USEC_W-1:0]       load_remain;
	logic [COUNTER_BITS-1:0] load_reload;

	// Start loads from the request, poll from the outstanding time
	assign load_src = (req == REQ_START) ? usecs : remain_cur;

	cmt_chunk #(
		.CYCLES_PER_USEC (CYCLES_PER_USEC),
		.COUNTER_BITS    (COUNTER_BITS)
	) u_chunk (
		.amount      (load_src),
		.remain_next (load_remain),
		.reload      (load_reload)
	);

	// Decode the request and advance the state
	always_comb begin
		remain_nxt     = remain_cur;
		reload_nxt     = reload_cur;
		count_nxt      = count_cur;
		on_nxt         = on_cur;
		wrap_nxt       = wrap_cur;
		result.expired = 1'b0;
		result.status  = 1'b0;
		case (req)
			REQ_TICK: begin
				if (on_cur) begin
					if (count_cur == '0) begin
						count_nxt = reload_cur;
					end else begin
						count_nxt = count_cur - CNT_ONE;
						if (count_cur == CNT_ONE) begin
							wrap_nxt = 1'b1;
						end
					end
				end
			end
			REQ_START: begin
				if (on_cur) begin
					result.status = 1'b1;
				end else begin
					remain_nxt = load_remain;
					reload_nxt = load_reload;
					count_nxt  = '0;
					wrap_nxt   = (load_reload == '0);
					on_nxt     = 1'b1;
				end
			end
			REQ_POLL: begin
				wrap_nxt = 1'b0;
				if (wrap_cur || !on_cur) begin
					if (remain_cur == '0) begin
						result.expired = 1'b1;
					end else begin
						remain_nxt = load_remain;
						reload_nxt = load_reload;
						count_nxt  = '0;
						wrap_nxt   = (load_reload == '0);
						on_nxt     = 1'b1;
					end
				end
			end
			default: begin
				on_nxt     = 1'b0;
				wrap_nxt   = 1'b0;
				remain_nxt = '0;
			end
		endcase
		result.running = on_nxt;
	end

endmodule

// File: rtl/chunked_microsecond_timeout_top.sv
// ----------------------------------------------------------------------------
// chunked_microsecond_timeout_top: long timeout on a tick-driven down-counter
// Input register, combinational state update, registered result.
// ----------------------------------------------------------------------------
// Accepts one request beat per clock cycle while not stalled and returns one
// result beat for each, in order. A request is captured in the input register,
// then its result in the result register, which holds it until it is taken;
// the rate of one beat per cycle is set by the counter state update in
// cmt_step, which is combinational so each request sees the state left by
// the one before. The input side stalls only while a result waits at the
// output and the input register is full. No clearing pass runs after reset.
module chunked_microsecond_timeout_top #(
	parameter int unsigned CYCLES_PER_USEC = 24,
	parameter int unsigned COUNTER_BITS    = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  req_type,
	input  logic [cmt_pkg::USEC_W-1:0]  usecs,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        expired,
	output logic                        status,
	output logic                        running
);
	import cmt_pkg::*;

	logic              valid_s1;
	req_t              req_s1;
	logic [USEC_W-1:0] usecs_s1;
	logic              advance;

	logic [USEC_W-1:0]       remain_q, remain_d;
	logic [COUNTER_BITS-1:0] reload_q, reload_d;
	logic [COUNTER_BITS-1:0] count_q, count_d;
	logic                    on_q, on_d;
	logic                    wrap_q, wrap_d;

	result_t result_d;
	result_t result_q;
	logic    out_valid_q;

	// Move the staged beat into the result register when it is free
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Capture the request beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1   <= req_t'(req_type);
			usecs_s1 <= usecs;
		end
	end

	cmt_step #(
		.CYCLES_PER_USEC (CYCLES_PER_USEC),
		.COUNTER_BITS    (COUNTER_BITS)
	) u_step (
		.req        (req_s1),
		.usecs      (usecs_s1),
		.remain_cur (remain_q),
		.reload_cur (reload_q),
		.count_cur  (count_q),
		.on_cur     (on_q),
		.wrap_cur   (wrap_q),
		.remain_nxt (remain_d),
		.reload_nxt (reload_d),
		.count_nxt  (count_d),
		.on_nxt     (on_d),
		.wrap_nxt   (wrap_d),
		.result     (result_d)
	);

	// Commit the counter state once per processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q <= '0;
			reload_q <= '0;
			count_q  <= '0;
			on_q     <= 1'b0;
			wrap_q   <= 1'b0;
		end else if (advance) begin
			remain_q <= remain_d;
			reload_q <= reload_d;
			count_q  <= count_d;
			on_q     <= on_d;
			wrap_q   <= wrap_d;
		end
	end

	// Hold the result beat until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign out_valid = out_valid_q;
	assign expired   = result_q.expired;
	assign status    = result_q.status;
	assign running   = result_q.running;

	// The reported enable bit matches the committed counter enable
	a_running_tracks_enable: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (running == on_q))
		else $error("running does not match counter enable");

	// A rejected start leaves the counter running
	a_reject_while_running: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> running)
		else $error("start rejected with counter off");

	// A pending wrap only exists while the counter is enabled
	a_wrap_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		wrap_q |-> on_q)
		else $error("wrap flag set with counter off");

	// Input stalls only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without output backpressure");

endmodule
